// ===== src/kss_pkg.sv =====
// Package for the k-th smallest select block.
// Holds default sizes, status codes and shared widths; no dependencies.
`default_nettype none
package kss_pkg;
    localparam int MaxElements = 1024;
    localparam int ValueWidth  = 32;
    localparam int KWidth      = 11;
    localparam int OutValueWidth = 32;
    localparam int OutPosWidth   = 10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANK_ERR = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;
endpackage
`default_nettype wire

// ===== src/kth_smallest_select.sv =====
// Top level of the k-th smallest select block.
// Uses kss_pkg and kss_ram (one RAM holding biased key and original position).
//
// Usage: samples arrive on the input channel (i_valid/o_ready), one beat per
// sample; i_last_sample closes the row. Each sample is written with its row
// position in one RAM entry; o_ready stays high while loading. On the last
// beat the block runs a median-of-three Hoare quickselect over the entries,
// one registered RAM read and at most one write per state: a compare reads
// both entries, then decides; a scan step reads and tests one entry; a swap
// reads both entries and writes them back in turn. Selection time is
// quadratic in the worst case. Then one result beat (o_valid/i_ready) gives
// the value, its original position and status. A rank error is answered in
// the cycle after the last beat. The input is held off from the last beat
// until the result is taken by the receiver; a stalled result simply holds.
// Samples past capacity are dropped and flag overflow. Reset clears the row,
// the overflow flag and the rank (to 1); RAM contents need no clearing.
// i_k_rank_we writes the rank; use it only while the block is idle (not enforced).
`default_nettype none
module kth_smallest_select
    import kss_pkg::*;
#(
    parameter int MAX_ELEMENTS = kss_pkg::MaxElements,
    parameter int VALUE_WIDTH  = kss_pkg::ValueWidth
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_k_rank_we,
    input  wire logic [kss_pkg::KWidth-1:0]         i_k_rank,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [VALUE_WIDTH-1:0]             i_sample_value,
    input  wire logic                               i_last_sample,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [kss_pkg::OutValueWidth-1:0]       o_kth_value,
    output logic [kss_pkg::OutPosWidth-1:0]         o_kth_position,
    output logic [1:0]                              o_status
);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = AW + 1;
    localparam int PW = AW;
    localparam int EW = VALUE_WIDTH + PW;
    localparam logic [CW-1:0] NMAX = CW'(MAX_ELEMENTS);

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_PAIR_A, S_PAIR_B, S_PAIR_C,
        S_SW_RA, S_SW_RB, S_SW_RC, S_SW_WA, S_SW_WB,
        S_M1_A, S_M1_B, S_M1_C, S_M2_A, S_M2_B, S_M2_C, S_M3_A, S_M3_B, S_M3_C,
        S_PIV_R, S_PIV_W, S_UP_R, S_UP_W, S_DN_R, S_DN_W, S_PART_CHK,
        S_FIN, S_NEXT, S_OUT_R, S_OUT_W, S_RESULT
    } t_state;

    // swap return points
    typedef enum logic [2:0] {
        RT_DONE, RT_M1, RT_M2, RT_M3, RT_PIV, RT_SCAN, RT_NEXT
    } t_ret;

    t_state r_state;
    t_ret   r_ret;
    logic [KWidth-1:0] r_k;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [AW-1:0] r_lo, r_hi;
    logic [CW:0]   r_up, r_dn;      // signed-ish, one extra bit for dn = lo-1 never needed
    logic [VALUE_WIDTH-1:0] r_piv;
    logic [AW-1:0] r_sa, r_sb;
    logic [EW-1:0] r_ea, r_eb;
    logic [VALUE_WIDTH-1:0] r_cmp;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [VALUE_WIDTH-1:0] rkey;
    logic [AW-1:0] k0;

    kss_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rkey    = rdata[EW-1:PW];
    assign k0      = AW'(r_k - KWidth'(1));
    assign o_ready = (r_state == S_LOAD);

    logic [VALUE_WIDTH-1:0] key_in;
    assign key_in = i_sample_value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [AW:0] mid_sum;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        we    = 1'b0;
        waddr = r_sa;
        wdata = r_eb;
        raddr = r_sa;
        unique case (r_state)
            S_LOAD: begin
                we    = i_valid && (r_count < NMAX);
                waddr = r_count[AW-1:0];
                wdata = {key_in, PW'(r_count)};
            end
            S_PAIR_A, S_M1_A, S_M2_A, S_M3_A, S_SW_RA: raddr = r_sa;
            S_PAIR_B, S_M1_B, S_M2_B, S_M3_B, S_SW_RB: raddr = r_sb;
            S_PIV_R: raddr = r_lo;
            S_UP_R:  raddr = r_up[AW-1:0];
            S_DN_R:  raddr = r_dn[AW-1:0];
            S_OUT_R: raddr = k0;
            S_SW_WA: begin
                we = 1'b1; waddr = r_sa; wdata = r_eb;
            end
            S_SW_WB: begin
                we = 1'b1; waddr = r_sb; wdata = r_ea;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ret   <= RT_DONE;
            r_k     <= KWidth'(1);
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_k_rank_we) begin
                r_k <= i_k_rank;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        logic [CW-1:0] n;
                        n = (r_count < NMAX) ? r_count + CW'(1) : r_count;
                        r_count <= n;
                        if (r_count >= NMAX) r_ovf <= 1'b1;
                        if (i_last_sample) begin
                            if (r_k == '0 || (CW+KWidth)'(r_k) > (CW+KWidth)'(n)) begin
                                o_kth_value    <= '0;
                                o_kth_position <= '0;
                                o_status       <= ST_RANK_ERR;
                                o_valid        <= 1'b1;
                                r_state        <= S_RESULT;
                            end else begin
                                r_lo    <= '0;
                                r_hi    <= AW'(n - CW'(1));
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    if (r_hi <= r_lo) begin
                        r_state <= S_OUT_R;
                    end else if (r_hi == r_lo + AW'(1)) begin
                        r_sa <= r_lo; r_sb <= r_hi; r_state <= S_PAIR_A;
                    end else begin
                        r_sa  <= mid_sum[AW:1];
                        r_sb  <= r_lo + AW'(1);
                        r_ret <= RT_M1;
                        r_state <= S_SW_RA;
                    end
                end
                // conditional swap: compare, then swap if a > b
                S_PAIR_A, S_M1_A, S_M2_A, S_M3_A: begin
                    r_state <= t_state'(r_state + 1);
                end
                S_PAIR_B, S_M1_B, S_M2_B, S_M3_B: begin
                    r_ea <= rdata; r_cmp <= rkey;
                    r_state <= t_state'(r_state + 1);
                end
                S_PAIR_C, S_M1_C, S_M2_C, S_M3_C: begin
                    r_eb <= rdata;
                    unique case (r_state)
                        S_PAIR_C: r_ret <= RT_DONE;
                        S_M1_C:   r_ret <= RT_M2;
                        S_M2_C:   r_ret <= RT_M3;
                        default:  r_ret <= RT_PIV;
                    endcase
                    if (r_cmp > rkey) begin
                        r_state <= S_SW_WA;
                    end else begin
                        unique case (r_state)
                            S_PAIR_C: r_state <= S_OUT_R;
                            S_M1_C: begin
                                r_sa <= r_lo; r_sb <= r_hi; r_state <= S_M2_A;
                            end
                            S_M2_C: begin
                                r_sa <= r_lo + AW'(1); r_sb <= r_lo; r_state <= S_M3_A;
                            end
                            default: r_state <= S_PIV_R;
                        endcase
                    end
                end
                S_SW_RA: r_state <= S_SW_RB;
                S_SW_RB: begin
                    r_ea <= rdata; r_state <= S_SW_RC;
                end
                S_SW_RC: begin
                    r_eb <= rdata; r_state <= S_SW_WA;
                end
                S_SW_WA: r_state <= S_SW_WB;
                S_SW_WB: begin
                    unique case (r_ret)
                        RT_DONE: r_state <= S_OUT_R;
                        RT_M1: begin
                            r_sa <= r_lo + AW'(1); r_sb <= r_hi; r_state <= S_M1_A;
                        end
                        RT_M2: begin
                            r_sa <= r_lo; r_sb <= r_hi; r_state <= S_M2_A;
                        end
                        RT_M3: begin
                            r_sa <= r_lo + AW'(1); r_sb <= r_lo; r_state <= S_M3_A;
                        end
                        RT_PIV:  r_state <= S_PIV_R;
                        RT_SCAN: r_state <= S_UP_R;
                        default: r_state <= S_FIN;
                    endcase
                end
                S_PIV_R: r_state <= S_PIV_W;
                S_PIV_W: begin
                    r_piv <= rkey;
                    r_up  <= (CW+1)'(r_lo) + (CW+1)'(2);
                    r_dn  <= (CW+1)'(r_hi) - (CW+1)'(1);
                    r_state <= S_UP_R;
                end
                S_UP_R: r_state <= S_UP_W;
                S_UP_W: begin
                    if (r_up < (CW+1)'(r_hi) && rkey < r_piv) begin
                        r_up <= r_up + (CW+1)'(1);
                        r_state <= S_UP_R;
                    end else begin
                        r_state <= S_DN_R;
                    end
                end
                S_DN_R: r_state <= S_DN_W;
                S_DN_W: begin
                    if (r_dn > (CW+1)'(r_lo) && rkey > r_piv) begin
                        r_dn <= r_dn - (CW+1)'(1);
                        r_state <= S_DN_R;
                    end else begin
                        r_state <= S_PART_CHK;
                    end
                end
                S_PART_CHK: begin
                    if (r_dn < r_up) begin
                        r_sa <= r_lo; r_sb <= r_dn[AW-1:0];
                        r_ret <= RT_NEXT;
                        r_state <= S_SW_RA;
                    end else begin
                        r_sa <= r_up[AW-1:0]; r_sb <= r_dn[AW-1:0];
                        r_ret <= RT_NEXT;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_ret == RT_NEXT && r_dn >= r_up) begin
                        // swap inside the scan, then continue scanning
                        r_ret <= RT_SCAN;
                        r_up  <= r_up + (CW+1)'(1);
                        r_dn  <= r_dn - (CW+1)'(1);
                        r_state <= S_SW_RA;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_dn <= (CW+1)'(k0)) r_lo <= r_up[AW-1:0];
                    if (r_dn >= (CW+1)'(k0)) r_hi <= AW'(r_dn - (CW+1)'(1));
                    r_state <= (r_dn == '0) ? S_OUT_R : S_START;
                end
                S_OUT_R: r_state <= S_OUT_W;
                S_OUT_W: begin
                    logic [VALUE_WIDTH-1:0] v;
                    v = rkey ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    o_kth_value    <= OutValueWidth'(v);
                    o_kth_position <= OutPosWidth'(rdata[PW-1:0]);
                    o_status       <= r_ovf ? ST_OVERFLOW : ST_OK;
                    o_valid        <= 1'b1;
                    r_state        <= S_RESULT;
                end
                S_RESULT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/kss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
